FILE: design/sfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types, constants and the crc-16/modbus byte update for the frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 29;

  localparam logic [7:0]  FIRST_SYNC_RST  = 8'h39;
  localparam logic [7:0]  SECOND_SYNC_RST = 8'h93;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  localparam logic CFG_FIRST_SYNC  = 1'b0;
  localparam logic CFG_SECOND_SYNC = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_CRC_BAD = 2'd1,
    ST_LEN_BAD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WR_ID,
    WR_CMD,
    WR_LEN,
    WR_DATA
  } wr_sel_t;

  typedef struct packed {
    logic    crc_init;
    logic    crc_feed;
    logic    store_wr;
    wr_sel_t wr_sel;
    logic    len_load;
    logic    cnt_clear;
    logic    cnt_inc;
    logic    crch_load;
    logic    idx_clear;
    logic    idx_inc;
    logic    rd_issue;
    logic    out_err;
    status_t err_status;
    logic    out_data;
  } cmd_t;

  typedef struct packed {
    logic first_hit;
    logic second_hit;
    logic len_big;
    logic len_zero;
    logic cnt_done;
    logic crc_ok;
    logic out_free;
    logic idx_last;
  } stat_t;

  // reflected crc-16/modbus, one byte
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/sfp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/sfp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_datapath
// sync registers, crc, length and count, frame store and output register
// ----------------------------------------------------------------------------
module sfp_datapath
  import sfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic [7:0]  rx_byte,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [4:0]       out_idx,
  output logic             out_last,
  output status_t          out_status
);

  localparam int STORE_SIZE = MAX_PAYLOAD + 3;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int CW         = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]    first_sync_r;
  logic [7:0]    second_sync_r;
  logic [15:0]   crc_r;
  logic [CW-1:0] len_r;
  logic [CW-1:0] cnt_r;
  logic [7:0]    crch_r;
  logic [AW-1:0] idx_r;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic [4:0]    out_idx_r;
  logic          out_last_r;
  status_t       out_status_r;

  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;

  always_comb begin
    unique case (cmd.wr_sel)
      WR_ID:   wr_addr = AW'(0);
      WR_CMD:  wr_addr = AW'(1);
      WR_LEN:  wr_addr = AW'(2);
      WR_DATA: wr_addr = AW'(3) + AW'(cnt_r);
      default: wr_addr = AW'(0);
    endcase
  end

  sfp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store_wr),
    .wr_addr (wr_addr),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= FIRST_SYNC_RST;
      second_sync_r <= SECOND_SYNC_RST;
      crc_r         <= CRC_INIT;
      len_r         <= '0;
      cnt_r         <= '0;
      crch_r        <= '0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIRST_SYNC:  first_sync_r  <= cfg_wdata;
          CFG_SECOND_SYNC: second_sync_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.crc_init) begin
        crc_r <= CRC_INIT;
      end else if (cmd.crc_feed) begin
        crc_r <= crc16_feed(crc_r, rx_byte);
      end
      if (cmd.len_load) begin
        len_r <= rx_byte[CW-1:0];
      end
      if (cmd.cnt_clear) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.crch_load) begin
        crch_r <= rx_byte;
      end
      if (cmd.idx_clear) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + AW'(1);
      end
      if (cmd.out_err || cmd.out_data) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_err) begin
      out_byte_r   <= 8'h00;
      out_idx_r    <= 5'd0;
      out_last_r   <= 1'b1;
      out_status_r <= cmd.err_status;
    end else if (cmd.out_data) begin
      out_byte_r   <= rd_data;
      out_idx_r    <= 5'(idx_r);
      out_last_r   <= stat.idx_last;
      out_status_r <= ST_GOOD;
    end
  end

  always_comb begin
    stat.first_hit  = (rx_byte == first_sync_r);
    stat.second_hit = (rx_byte == second_sync_r);
    stat.len_big    = (rx_byte > 8'(MAX_PAYLOAD));
    stat.len_zero   = (rx_byte == 8'h00);
    stat.cnt_done   = ({1'b0, cnt_r} + (CW+1)'(1)) >= {1'b0, len_r};
    stat.crc_ok     = ({crch_r, rx_byte} == crc_r);
    stat.out_free   = !out_valid_r || out_ready;
    stat.idx_last   = (idx_r == (AW'(len_r) + AW'(2)));
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_idx    = out_idx_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

FILE: design/sfp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_ctrl
// frame phase state machine and emit sequencer
// ----------------------------------------------------------------------------
module sfp_ctrl
  import sfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_HUNT1,
    S_HUNT2,
    S_ID,
    S_CMD,
    S_LEN,
    S_DATA,
    S_CRCH,
    S_CRCL,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_comb begin
    unique case (state_r)
      S_LEN, S_CRCL:        in_ready = stat.out_free;
      S_EMIT_RD, S_EMIT_LD: in_ready = 1'b0;
      default:              in_ready = 1'b1;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.wr_sel = WR_ID;
    state_nxt  = state_r;
    unique case (state_r)
      S_HUNT1: begin
        if (accept && stat.first_hit) begin
          cmd.crc_init  = 1'b1;
          cmd.cnt_clear = 1'b1;
          state_nxt     = S_HUNT2;
        end
      end
      S_HUNT2: begin
        if (accept) begin
          state_nxt = stat.second_hit ? S_ID : S_HUNT1;
        end
      end
      S_ID: begin
        if (accept) begin
          cmd.store_wr = 1'b1;
          cmd.wr_sel   = WR_ID;
          cmd.crc_feed = 1'b1;
          state_nxt    = S_CMD;
        end
      end
      S_CMD: begin
        if (accept) begin
          cmd.store_wr = 1'b1;
          cmd.wr_sel   = WR_CMD;
          cmd.crc_feed = 1'b1;
          state_nxt    = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          if (stat.len_big) begin
            cmd.out_err    = 1'b1;
            cmd.err_status = ST_LEN_BAD;
            state_nxt      = S_HUNT1;
          end else begin
            cmd.store_wr  = 1'b1;
            cmd.wr_sel    = WR_LEN;
            cmd.crc_feed  = 1'b1;
            cmd.len_load  = 1'b1;
            cmd.cnt_clear = 1'b1;
            state_nxt     = stat.len_zero ? S_CRCH : S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd.store_wr = 1'b1;
          cmd.wr_sel   = WR_DATA;
          cmd.crc_feed = 1'b1;
          cmd.cnt_inc  = 1'b1;
          if (stat.cnt_done) begin
            state_nxt = S_CRCH;
          end
        end
      end
      S_CRCH: begin
        if (accept) begin
          cmd.crch_load = 1'b1;
          state_nxt     = S_CRCL;
        end
      end
      S_CRCL: begin
        if (accept) begin
          if (stat.crc_ok) begin
            cmd.idx_clear = 1'b1;
            state_nxt     = S_EMIT_RD;
          end else begin
            cmd.out_err    = 1'b1;
            cmd.err_status = ST_CRC_BAD;
            state_nxt      = S_HUNT1;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.out_data = 1'b1;
          if (stat.idx_last) begin
            state_nxt = S_HUNT1;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_HUNT1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/sync_frame_parser_crc16_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_parser_crc16_unit
// sync-framed byte parser with crc-16/modbus check and frame replay
// ----------------------------------------------------------------------------
// While parsing, one received byte is taken per cycle; the length byte and the
// low crc byte wait until the output register is free, since either may carry a
// result. After a good crc the stored frame is replayed from the frame ram, each
// byte passing a registered ram read and then a load of the output register, and
// no byte is taken meanwhile. A bad crc or an oversize length gives a single
// result with tlast set. The frame ram needs no clearing pass after reset.
module sync_frame_parser_crc16_unit
  import sfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] frame_byte, [12:8] byte_index, zero pad
  output logic             out_tlast,  // is_last
  output logic [1:0]       out_tuser   // [1:0] status
);

  cmd_t    cmd;
  stat_t   stat;
  logic [7:0] out_byte;
  logic [4:0] out_idx;
  status_t out_status;

  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfp_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .rx_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_byte),
    .out_idx    (out_idx),
    .out_last   (out_tlast),
    .out_status (out_status)
  );

  assign out_tdata = {3'b000, out_idx, out_byte};
  assign out_tuser = out_status;

endmodule
`default_nettype wire

FILE: design/sfp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_checker
// port-level checks for the frame parser, bound to the top level
// ----------------------------------------------------------------------------
module sfp_checker
  import sfp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [1:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // error results are single, zeroed and marked last
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_GOOD) |-> out_tlast && (out_tdata == 16'h0000))
    else $error("malformed error result");

  // no byte is taken while a frame replay is in progress
  a_replay_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_GOOD) && !out_tlast |-> !in_tready)
    else $error("input taken during frame replay");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sync_frame_parser_crc16_unit sfp_checker u_sfp_checker (.*);
`default_nettype wire

FILE: verif/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_tb_checker
// watches the byte, result and register ports of the sync frame parser, keeps
// its own parse state, crc and frame copy, and compares every result transfer
// in order against the predicted frame bytes and error results
// ----------------------------------------------------------------------------
module sfp_tb_checker
  import sfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,  // [7:0] frame_byte, [12:8] byte_index
  input  wire logic        out_tlast,  // is_last
  input  wire logic [1:0]  out_tuser,  // [1:0] status
  output int               expected_count,
  output int               fail_count
);

  localparam int FRAME_DEPTH = MAX_PAYLOAD + 3;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_ID,
    GET_CMD,
    GET_LEN,
    GET_DATA,
    GET_CRC_HI,
    GET_CRC_LO
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       is_last;
    status_t    status;
  } frame_res_t;

  logic [7:0]   sync_first;
  logic [7:0]   sync_second;
  parse_phase_t parse_phase;
  logic [7:0]   frame_copy [FRAME_DEPTH];
  logic [7:0]   payload_len;
  logic [4:0]   payload_cnt;
  logic [15:0]  crc_acc;
  logic [7:0]   crc_hi_byte;
  frame_res_t   frame_res_q [$];
  frame_res_t   want;

  initial fail_count = 0;
  initial expected_count = 0;

  function automatic logic [15:0] modbus_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = {1'b0, c[15:1]} ^ (fb ? 16'hA001 : 16'h0000);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < 40) begin
      $display("%0t: sfp mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  task automatic push_result(input logic [7:0] b, input logic [4:0] idx, input logic last,
                             input status_t st);
    frame_res_t r;
    r.frame_byte = b;
    r.byte_index = idx;
    r.is_last    = last;
    r.status     = st;
    frame_res_q.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int total;
    case (parse_phase)
      HUNT_FIRST: begin
        if (b == sync_first) begin
          parse_phase = HUNT_SECOND;
          payload_cnt = '0;
          crc_acc     = CRC_INIT;
        end
      end
      HUNT_SECOND: begin
        parse_phase = (b == sync_second) ? GET_ID : HUNT_FIRST;
      end
      GET_ID: begin
        frame_copy[0] = b;
        crc_acc       = modbus_crc_step(crc_acc, b);
        parse_phase   = GET_CMD;
      end
      GET_CMD: begin
        frame_copy[1] = b;
        crc_acc       = modbus_crc_step(crc_acc, b);
        parse_phase   = GET_LEN;
      end
      GET_LEN: begin
        if (b > MAX_PAYLOAD) begin
          push_result(8'h00, 5'd0, 1'b1, ST_LEN_BAD);
          parse_phase = HUNT_FIRST;
        end else begin
          frame_copy[2] = b;
          crc_acc       = modbus_crc_step(crc_acc, b);
          payload_len   = b;
          payload_cnt   = '0;
          parse_phase   = (b == 8'd0) ? GET_CRC_HI : GET_DATA;
        end
      end
      GET_DATA: begin
        frame_copy[3 + payload_cnt] = b;
        crc_acc     = modbus_crc_step(crc_acc, b);
        payload_cnt = payload_cnt + 5'd1;
        if (payload_cnt >= payload_len) begin
          parse_phase = GET_CRC_HI;
        end
      end
      GET_CRC_HI: begin
        crc_hi_byte = b;
        parse_phase = GET_CRC_LO;
      end
      default: begin
        parse_phase = HUNT_FIRST;
        if ({crc_hi_byte, b} != crc_acc) begin
          push_result(8'h00, 5'd0, 1'b1, ST_CRC_BAD);
        end else begin
          total = int'(payload_len) + 3;
          for (int i = 0; i < total; i++) begin
            push_result(frame_copy[i], 5'(i), (i == total - 1), ST_GOOD);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_first  = FIRST_SYNC_RST;
      sync_second = SECOND_SYNC_RST;
      parse_phase = HUNT_FIRST;
      payload_len = '0;
      payload_cnt = '0;
      crc_acc     = CRC_INIT;
      crc_hi_byte = '0;
      frame_res_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST_SYNC) begin
          sync_first = cfg_wdata;
        end else begin
          sync_second = cfg_wdata;
        end
      end
      if (out_tvalid && out_tready) begin
        if (frame_res_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer, tdata %h", out_tdata));
        end else begin
          want = frame_res_q.pop_front();
          if (out_tdata[7:0] !== want.frame_byte) begin
            report_mismatch($sformatf("frame_byte %h, want %h", out_tdata[7:0],
                                      want.frame_byte));
          end
          if (out_tdata[12:8] !== want.byte_index) begin
            report_mismatch($sformatf("byte_index %0d, want %0d", out_tdata[12:8],
                                      want.byte_index));
          end
          if (out_tlast !== want.is_last) begin
            report_mismatch($sformatf("tlast %b, want %b", out_tlast, want.is_last));
          end
          if (out_tuser !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
          end
        end
      end
    end
    expected_count <= frame_res_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the sync frame parser: directed corner frames, then random
// good, corrupted, oversize and broken frames over several sync settings and
// idle/stall mixes, with one long receiver hold-off to back up the input
// ----------------------------------------------------------------------------
module tb_top;
  import sfp_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_BYTES   = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 80;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_FIRST_SYNC;
  logic [7:0]  cfg_wdata  = 8'h00;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  int          expected_count;
  int          fail_count;
  int          cycle_count = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          bytes_sent  = 0;
  int          hold_left   = 0;
  logic        hold_arm    = 1'b0;
  logic        hold_used   = 1'b0;
  logic [7:0]  sync_a      = FIRST_SYNC_RST;
  logic [7:0]  sync_b      = SECOND_SYNC_RST;

  always #5 clk = ~clk;

  sync_frame_parser_crc16_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  sfp_tb_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .expected_count (expected_count),
    .fail_count     (fail_count)
  );

  // receiver: random stalls, plus one long hold-off when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_arm && !hold_used) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_used  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sync_frame_parser_crc16_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [15:0] frame_crc(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = {1'b0, c[15:1]} ^ (fb ? 16'hA001 : 16'h0000);
    end
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit bad_crc);
    logic [7:0]  body [$];
    logic [15:0] crc;
    body = {};
    body.push_back(8'($urandom_range(255)));
    body.push_back(8'($urandom_range(255)));
    body.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom_range(255)));
    end
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = frame_crc(crc, body[i]);
    end
    if (bad_crc) begin
      crc = crc ^ 16'($urandom_range(65535, 1));
    end
    send_byte(sync_a);
    send_byte(sync_b);
    foreach (body[i]) begin
      send_byte(body[i]);
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  task automatic send_oversize(input logic [7:0] len);
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
    send_byte(len);
  endtask

  // frame cut short; the next bytes get absorbed into it
  task automatic send_truncated();
    int len;
    len = $urandom_range(MAX_PAYLOAD_DEF, 1);
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
    send_byte(8'(len));
    repeat ($urandom_range(len - 1)) send_byte(8'($urandom_range(255)));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      return MAX_PAYLOAD_DEF;
    end else if (r < 70) begin
      return $urandom_range(5);
    end
    return $urandom_range(MAX_PAYLOAD_DEF);
  endfunction

  task automatic settle(input int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_count != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_FIRST_SYNC) begin
      sync_a = v;
    end else begin
      sync_b = v;
    end
  endtask

  task automatic random_traffic(input int nbytes);
    int stop_at;
    int pick;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        send_frame(pick_len(), 1'b0);
      end else if (pick < 74) begin
        send_frame(pick_len(), 1'b1);
      end else if (pick < 81) begin
        send_oversize($urandom_range(1) ? 8'(MAX_PAYLOAD_DEF + 1)
                                        : 8'($urandom_range(255, MAX_PAYLOAD_DEF + 1)));
      end else if (pick < 88) begin
        send_byte(sync_a);
        send_byte(sync_b ^ 8'($urandom_range(255, 1)));
      end else if (pick < 94) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        send_truncated();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners with reset sync values
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sync_a);
    send_byte(sync_a);
    send_byte(sync_b);
    send_frame(0, 1'b0);
    send_oversize(8'(MAX_PAYLOAD_DEF + 1));
    send_oversize(8'hFF);
    send_frame(1, 1'b1);

    // no idling, with the long receiver hold-off
    random_traffic(PHASE_BYTES / 2);
    hold_arm <= 1'b1;
    send_frame(MAX_PAYLOAD_DEF, 1'b0);
    send_frame(MAX_PAYLOAD_DEF, 1'b0);
    random_traffic(PHASE_BYTES / 2);

    settle(SETTLE_CYCLES);
    write_reg(CFG_FIRST_SYNC, 8'h00);
    write_reg(CFG_SECOND_SYNC, 8'hFF);
    idle_pct  = 65;
    stall_pct = 0;
    random_traffic(PHASE_BYTES);

    settle(SETTLE_CYCLES);
    write_reg(CFG_FIRST_SYNC, 8'hFF);
    write_reg(CFG_SECOND_SYNC, 8'h00);
    idle_pct  = 0;
    stall_pct = 65;
    random_traffic(PHASE_BYTES);

    // both sync bytes equal
    settle(SETTLE_CYCLES);
    write_reg(CFG_FIRST_SYNC, 8'($urandom_range(255)));
    write_reg(CFG_SECOND_SYNC, sync_a);
    idle_pct  = 28;
    stall_pct = 28;
    random_traffic(PHASE_BYTES);

    settle(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("sync_frame_parser_crc16_unit regression: pass");
    end else begin
      $display("sync_frame_parser_crc16_unit regression: fail");
    end
    $finish;
  end

endmodule
